/* hdl/sipq_pkg.sv */
// ----------------------------------------------------------------------------
// sipq_pkg
// Shared types and codes for the sorted insert / pop-min queue.
// ----------------------------------------------------------------------------
`default_nettype none

package sipq_pkg;

  // Command codes of the input word
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  // Status codes of the result word
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // Fixed widths of the port fields
  localparam int KEY_PORT_W   = 16;
  localparam int COUNT_PORT_W = 5;

  // Operation broadcast to every cell of the chain
  typedef struct packed {
    logic ins;
    logic pop;
  } cell_ctrl_t;

endpackage

`default_nettype wire

/* hdl/sorted_insert_pop_min_queue_top.sv */
// ----------------------------------------------------------------------------
// sorted_insert_pop_min_queue_top
// Bounded priority queue built as a row of compare-and-shift cells.
// ----------------------------------------------------------------------------
//
// Each command word is accepted at an edge where start is high and busy is
// low, the whole cell row updates in parallel at the next edge (busy is high
// in between), and the result word is shown for exactly one cycle with done
// high right after. The receiver cannot stall: sample status, count,
// head_key and is_empty in the cycle done is high, since they are not held
// afterwards. A new word may be started in that same done cycle, but none is
// taken while busy is high. Inserts into a full queue return status full and
// removes from an empty queue return status empty; both leave the contents
// untouched. After reset the queue is empty and ready.
//
`default_nettype none

module sorted_insert_pop_min_queue_top #(
  parameter int CAPACITY = 16,
  parameter int KEY_BITS = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  start,
  output logic                                       busy,
  input  wire logic                                  command,
  input  wire logic [sipq_pkg::KEY_PORT_W-1:0]       key,
  output logic                                       done,
  output logic      [1:0]                            status,
  output logic      [sipq_pkg::COUNT_PORT_W-1:0]     count,
  output logic      [sipq_pkg::KEY_PORT_W-1:0]       head_key,
  output logic                                       is_empty
);
  import sipq_pkg::*;

  localparam int OCC_W = $clog2(CAPACITY + 1);

  // Latched command word
  logic                cmd_q;
  logic [KEY_BITS-1:0] key_q;

  // Queue occupancy
  logic [OCC_W-1:0] occ;

  // Cell row
  logic [KEY_BITS-1:0] cell_key [CAPACITY];
  logic [CAPACITY-1:0] cell_valid;
  logic [CAPACITY-1:0] cell_gt;

  logic       full;
  logic       empty;
  cell_ctrl_t ctrl;
  logic [1:0] status_next;

  // Valid cells are packed from slot zero, so the ends tell full and empty
  assign full  = cell_valid[CAPACITY-1];
  assign empty = !cell_valid[0];

  // Drive the row only in the update cycle, and only for a legal operation
  always_comb begin
    ctrl.ins    = busy && (cmd_q == CMD_INSERT) && !full;
    ctrl.pop    = busy && (cmd_q == CMD_REMOVE) && !empty;
    status_next = ST_DONE;
    if (cmd_q == CMD_INSERT && full) begin
      status_next = ST_FULL;
    end else if (cmd_q == CMD_REMOVE && empty) begin
      status_next = ST_EMPTY;
    end
  end

  // Sequence: accept -> update -> show result
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      occ  <= '0;
    end else begin
      done <= busy;
      if (busy) begin
        busy <= 1'b0;
      end else if (start) begin
        busy <= 1'b1;
      end
      if (ctrl.ins) begin
        occ <= occ + OCC_W'(1);
      end else if (ctrl.pop) begin
        occ <= occ - OCC_W'(1);
      end
    end
  end

  // Hold the command word and the status; payload needs no reset
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      cmd_q <= command;
      key_q <= KEY_BITS'(key);
    end
    if (busy) begin
      status <= status_next;
    end
  end

  // Each cell sees its left and right neighbor; the first sees the new key, the last an empty slot
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [KEY_BITS-1:0] l_key;
    logic                l_valid;
    logic                l_gt;
    logic [KEY_BITS-1:0] r_key;
    logic                r_valid;

    if (i == 0) begin : g_first
      assign l_key   = key_q;
      assign l_valid = 1'b1;
      assign l_gt    = 1'b0;
    end else begin : g_inner_l
      assign l_key   = cell_key[i-1];
      assign l_valid = cell_valid[i-1];
      assign l_gt    = cell_gt[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign r_key   = '0;
      assign r_valid = 1'b0;
    end else begin : g_inner_r
      assign r_key   = cell_key[i+1];
      assign r_valid = cell_valid[i+1];
    end

    sipq_cell #(
      .KEY_BITS(KEY_BITS)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .new_key    (key_q),
      .left_key   (l_key),
      .left_valid (l_valid),
      .left_gt    (l_gt),
      .right_key  (r_key),
      .right_valid(r_valid),
      .key        (cell_key[i]),
      .valid      (cell_valid[i]),
      .gt         (cell_gt[i])
    );
  end

  // Result fields come from the occupancy count and the row; stable through the done cycle
  assign count    = COUNT_PORT_W'(occ);
  assign head_key = cell_valid[0] ? KEY_PORT_W'(cell_key[0]) : '0;
  assign is_empty = (occ == '0);

endmodule

`default_nettype wire

/* hdl/sipq_cell.sv */
// ----------------------------------------------------------------------------
// sipq_cell
// One slot of the sorted chain: holds a key and a valid flag, shifts right
// on insert and left on pop.
// ----------------------------------------------------------------------------
`default_nettype none

module sipq_cell #(
  parameter int KEY_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire sipq_pkg::cell_ctrl_t  ctrl,
  input  wire logic [KEY_BITS-1:0]   new_key,
  input  wire logic [KEY_BITS-1:0]   left_key,
  input  wire logic                  left_valid,
  input  wire logic                  left_gt,
  input  wire logic [KEY_BITS-1:0]   right_key,
  input  wire logic                  right_valid,
  output logic      [KEY_BITS-1:0]   key,
  output logic                       valid,
  output logic                       gt
);
  import sipq_pkg::*;

  logic take_left;
  logic take_new;

  // Cell holds a key strictly above the incoming one
  assign gt        = valid && (key > new_key);
  assign take_left = left_gt;
  assign take_new  = !left_gt && (gt || (!valid && left_valid));

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.ins) begin
      if (take_left) begin
        valid <= left_valid;
      end else if (take_new) begin
        valid <= 1'b1;
      end
    end else if (ctrl.pop) begin
      valid <= right_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      if (take_left) begin
        key <= left_key;
      end else if (take_new) begin
        key <= new_key;
      end
    end else if (ctrl.pop) begin
      key <= right_key;
    end
  end

endmodule

`default_nettype wire

/* tb/sorted_insert_pop_min_queue_top_test.sv */
// ----------------------------------------------------------------------------
// sorted_insert_pop_min_queue_top_test
// Self-checking bench for the bounded sorted priority queue.
// ----------------------------------------------------------------------------
//
// Insert and remove-min words are pushed into the block through the
// start/busy handshake. A local model keeps the held keys as a sorted
// list, so every accepted word gets an expected status, count, head key
// and empty flag. A checker compares each done strobe with the oldest
// expectation.
//
// The directed tests cover the following cases:
//   - removes on an empty queue
//   - extreme keys
//   - keys equal to the head, the tail and a middle entry
//   - a fill to capacity, then inserts refused as full
//
// A long random phase follows. It switches between insert-heavy,
// balanced and remove-heavy mixes, and its keys are full-range, small
// (many duplicates) or near the extremes. Sender bursts and gaps are
// random, and the sender waits for every outstanding result from time to time.
//
module sorted_insert_pop_min_queue_top_test;
  import sipq_pkg::*;

  localparam int QUEUE_DEPTH  = 16;
  localparam int RANDOM_WORDS = 400;
  localparam int CYCLE_LIMIT  = 100000;
  localparam int TAIL_CYCLES  = 8;

  typedef struct packed {
    logic [1:0]              status;
    logic [COUNT_PORT_W-1:0] count;
    logic [KEY_PORT_W-1:0]   head_key;
    logic                    is_empty;
  } queue_result_t;

  logic                    clk;
  logic                    rst;
  logic                    start;
  logic                    busy;
  logic                    command;
  logic [KEY_PORT_W-1:0]   key;
  logic                    done;
  logic [1:0]              status;
  logic [COUNT_PORT_W-1:0] count;
  logic [KEY_PORT_W-1:0]   head_key;
  logic                    is_empty;

  // Model state: held keys in ascending order, plus expected results in flight
  logic [KEY_PORT_W-1:0] held_keys[$];
  queue_result_t         pending_results[$];

  int error_count;
  int cycle_count;
  int insert_words;
  int remove_words;
  int full_refusals;
  int empty_refusals;
  int peak_count;
  int checked_words;

  sorted_insert_pop_min_queue_top #(
    .CAPACITY (QUEUE_DEPTH),
    .KEY_BITS (KEY_PORT_W)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .command  (command),
    .key      (key),
    .done     (done),
    .status   (status),
    .count    (count),
    .head_key (head_key),
    .is_empty (is_empty)
  );

  // 10-unit clock: 5 high, 5 low
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Watchdog: end the run if results stop arriving
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still expected", cycle_count,
               pending_results.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // Apply one word to the sorted-list model and return the result it yields.
  // Equal keys may sit in any order among themselves: only the smallest key
  // and the number held are visible, so a plain sorted list is enough.
  function automatic queue_result_t apply_queue_word(logic cmd, logic [KEY_PORT_W-1:0] k);
    queue_result_t res;
    int            pos;
    res.status = ST_DONE;
    if (cmd == CMD_INSERT) begin
      if (held_keys.size() >= QUEUE_DEPTH) begin
        res.status = ST_FULL;
      end else begin
        pos = 0;
        while (pos < held_keys.size() && held_keys[pos] <= k) pos++;
        held_keys.insert(pos, k);
      end
    end else begin
      if (held_keys.size() == 0) res.status = ST_EMPTY;
      else void'(held_keys.pop_front());
    end
    res.count    = COUNT_PORT_W'(held_keys.size());
    res.head_key = (held_keys.size() != 0) ? held_keys[0] : '0;
    res.is_empty = (held_keys.size() == 0);
    return res;
  endfunction

  // Present one word and hold it until the block takes it. Leave start high
  // on return so that a back-to-back word needs no extra cycle.
  task automatic issue_word(logic cmd, logic [KEY_PORT_W-1:0] k);
    queue_result_t res;
    start   <= 1'b1;
    command <= cmd;
    key     <= k;
    // busy is read before the edge updates it, so this sees the handshake
    // exactly as the block does
    do @(posedge clk); while (busy !== 1'b0);
    res = apply_queue_word(cmd, k);
    pending_results.push_back(res);
    if (cmd == CMD_INSERT) insert_words++;
    else remove_words++;
    if (res.status == ST_FULL) full_refusals++;
    if (res.status == ST_EMPTY) empty_refusals++;
    if (held_keys.size() > peak_count) peak_count = held_keys.size();
  endtask

  // Drop start for the given pause; scramble the payload to show it is ignored
  task automatic pause_sender(int cycles);
    start   <= 1'b0;
    command <= 1'($urandom());
    key     <= KEY_PORT_W'($urandom());
    repeat (cycles) @(posedge clk);
  endtask

  // Hold off the sender until every expected word has come back
  task automatic wait_until_drained();
    start <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic check_field(string name, logic [KEY_PORT_W-1:0] want,
                             logic [KEY_PORT_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  // Result checker: the strobe lasts one cycle and cannot be stalled, so
  // sample every edge at which done was high
  always @(posedge clk) begin
    queue_result_t want;
    if (rst === 1'b0 && done === 1'b1) begin
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected: status %0d count %0d head_key %0d",
               status, count, head_key);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", KEY_PORT_W'(want.status), KEY_PORT_W'(status));
        check_field("count", KEY_PORT_W'(want.count), KEY_PORT_W'(count));
        check_field("head_key", want.head_key, head_key);
        check_field("is_empty", KEY_PORT_W'(want.is_empty), KEY_PORT_W'(is_empty));
        checked_words++;
      end
    end
  end

  // Removes right after reset must be refused and leave the queue empty
  task automatic test_remove_when_empty();
    issue_word(CMD_REMOVE, 16'h0000);
    issue_word(CMD_REMOVE, 16'hFFFF);
    wait_until_drained();
  endtask

  // Fill back to back with extreme and duplicate keys, then push past
  // capacity and take a couple off the front
  task automatic test_fill_past_capacity();
    logic [KEY_PORT_W-1:0] fill_keys[16];
    fill_keys = '{16'h8000, 16'h8000, 16'h0000, 16'h0000,
                  16'hFFFF, 16'hFFFF, 16'h8000, 16'h1234,
                  16'hAAAA, 16'h5555, 16'h7FFF, 16'h0001,
                  16'hFFFE, 16'h4000, 16'hC000, 16'h8001};
    // first two: equal to head and tail at once; then new head, equal to
    // head, new tail, equal to tail, equal to a middle entry
    foreach (fill_keys[i]) issue_word(CMD_INSERT, fill_keys[i]);
    issue_word(CMD_INSERT, 16'h0000);
    issue_word(CMD_INSERT, 16'hFFFF);
    issue_word(CMD_REMOVE, 16'h5A5A);
    issue_word(CMD_REMOVE, 16'hA5A5);
    wait_until_drained();
  endtask

  // Random mix, reshaped every few dozen words so the queue swings between
  // empty and full; bursts and gaps of random length in between
  task automatic test_random_traffic();
    int                    sent;
    int                    mix_left;
    int                    insert_pct;
    int                    key_style;
    int                    burst_left;
    logic                  cmd;
    logic [KEY_PORT_W-1:0] k;
    sent       = 0;
    mix_left   = 0;
    insert_pct = 50;
    key_style  = 0;
    burst_left = $urandom_range(8, 1);
    while (sent < RANDOM_WORDS) begin
      if (mix_left == 0) begin
        mix_left = $urandom_range(40, 12);
        case ($urandom_range(2, 0))
          0:       insert_pct = 25;
          1:       insert_pct = 50;
          default: insert_pct = 80;
        endcase
        key_style = $urandom_range(2, 0);
      end
      cmd = ($urandom_range(99, 0) < insert_pct) ? CMD_INSERT : CMD_REMOVE;
      case (key_style)
        0:       k = KEY_PORT_W'($urandom());
        1:       k = KEY_PORT_W'($urandom_range(7, 0));
        default: k = $urandom_range(1, 0) ? 16'hFFFF - KEY_PORT_W'($urandom_range(3, 0))
                                          : KEY_PORT_W'($urandom_range(3, 0));
      endcase
      issue_word(cmd, k);
      sent++;
      mix_left--;
      burst_left--;
      if (sent % 100 == 0) begin
        wait_until_drained();
      end else if (burst_left == 0) begin
        pause_sender($urandom_range(6, 1));
        // now and then a long burst with no gaps at all
        burst_left = ($urandom_range(3, 0) == 0) ? 30 : $urandom_range(8, 1);
      end
    end
    wait_until_drained();
  endtask

  initial begin
    error_count    = 0;
    cycle_count    = 0;
    insert_words   = 0;
    remove_words   = 0;
    full_refusals  = 0;
    empty_refusals = 0;
    peak_count     = 0;
    checked_words  = 0;
    rst     = 1'b1;
    start   = 1'b0;
    command = CMD_INSERT;
    key     = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_remove_when_empty();
    test_fill_past_capacity();
    test_random_traffic();

    // let any stray strobe show up before judging
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d expected words never arrived", pending_results.size());
      error_count++;
    end

    $display("checked %0d result words: %0d inserts, %0d removes, peak occupancy %0d",
             checked_words, insert_words, remove_words, peak_count);
    $display("refused %0d inserts on a full queue and %0d removes on an empty one",
             full_refusals, empty_refusals);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
